// ----- rtl/tcgr_pkg.sv -----
package tcgr_pkg;

   // Font geometry
   localparam int GLYPH_COUNT_DEFAULT = 256;
   localparam int GLYPH_ROWS          = 16;
   localparam int ROW_W               = $clog2(GLYPH_ROWS);
   localparam int ROW_CNT_W           = $clog2(GLYPH_ROWS + 1);

   // Character codes with a meaning of their own
   localparam logic [7:0] CODE_NUL = 8'h00;
   localparam logic [7:0] CODE_TAB = 8'h09;
   localparam logic [7:0] CODE_LF  = 8'h0A;

   // Foreground gray and the pixel depths that draw
   localparam logic [7:0] GREY     = 8'hC0;
   localparam logic [5:0] DEPTH_16 = 6'd16;
   localparam logic [5:0] DEPTH_32 = 6'd32;
   localparam logic [3:0] CHAN_MAX = 4'd8;

   // Register reset values
   localparam logic [31:0] FRAME_BASE_RST     = 32'd0;
   localparam logic [15:0] LINE_PITCH_RST     = 16'd4096;
   localparam logic [5:0]  PIXEL_DEPTH_RST    = 6'd32;
   localparam logic [7:0]  COLUMN_LIMIT_RST   = 8'd128;
   localparam logic [4:0]  RED_POSITION_RST   = 5'd16;
   localparam logic [4:0]  GREEN_POSITION_RST = 5'd8;
   localparam logic [4:0]  BLUE_POSITION_RST  = 5'd0;
   localparam logic [11:0] CHANNEL_SIZES_RST  = 12'd1416;

   typedef enum logic [2:0] {
      CSR_FRAME_BASE     = 3'd0,
      CSR_LINE_PITCH     = 3'd1,
      CSR_PIXEL_DEPTH    = 3'd2,
      CSR_COLUMN_LIMIT   = 3'd3,
      CSR_RED_POSITION   = 3'd4,
      CSR_GREEN_POSITION = 3'd5,
      CSR_BLUE_POSITION  = 3'd6,
      CSR_CHANNEL_SIZES  = 3'd7
   } csr_index_type;

   typedef enum logic {
      KIND_PRINT = 1'b0,
      KIND_FONT  = 1'b1
   } item_kind_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MULT,
      ST_BASE,
      ST_ROWS
   } ctrl_state_type;

   // Controller to datapath
   typedef struct packed {
      logic             accept;     // input beat taken this cycle
      logic             mult;       // register products and color
      logic             base;       // form base address, advance cursor
      logic             issue;      // font read for issue_row
      logic [ROW_W-1:0] issue_row;
      logic             load_out;   // move font data into output register
      logic             load_last;  // that beat is the final glyph row
   } dp_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic draw;  // offered input beat is a character that renders
   } dp_status_type;

endpackage

// ----- rtl/tcgr_req_if.sv -----
interface tcgr_req_if;
   logic       valid;
   logic       ready;
   logic       kind;
   logic [7:0] char_code;
   logic [3:0] glyph_row;
   logic [7:0] font_byte;

   modport source (output valid, kind, char_code, glyph_row, font_byte, input ready);
   modport sink   (input valid, kind, char_code, glyph_row, font_byte, output ready);
endinterface

// ----- rtl/tcgr_rsp_if.sv -----
interface tcgr_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] write_address;
   logic [31:0] pixel_0;
   logic [31:0] pixel_1;
   logic [31:0] pixel_2;
   logic [31:0] pixel_3;
   logic [31:0] pixel_4;
   logic [31:0] pixel_5;
   logic [31:0] pixel_6;
   logic [31:0] pixel_7;
   logic        last_row;

   modport source (output valid, write_address, pixel_0, pixel_1, pixel_2, pixel_3,
                   pixel_4, pixel_5, pixel_6, pixel_7, last_row, input ready);
   modport sink   (input valid, write_address, pixel_0, pixel_1, pixel_2, pixel_3,
                   pixel_4, pixel_5, pixel_6, pixel_7, last_row, output ready);
endinterface

// ----- rtl/text_console_glyph_renderer_top.sv -----
// Font writes, newline, tab and code 0 are taken without leaving idle.
// Drawn character: accept, multiply, base add, 16 font RAM reads and the last row load;
// the first row beat follows the first read, and sink stalls hold the row loads.
// The next item is taken the cycle after the last row enters the output register.
// Synchronous active-high reset restores register defaults and homes the cursor;
// font RAM contents are not cleared.
module text_console_glyph_renderer_top #(
   parameter int GLYPH_COUNT = tcgr_pkg::GLYPH_COUNT_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   tcgr_req_if.sink                req_ch,
   tcgr_rsp_if.source              rsp_ch,
   input  logic                    csr_write_enable,
   input  tcgr_pkg::csr_index_type csr_index,
   input  logic [31:0]             csr_write_data
);
   import tcgr_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   tcgr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_ready (rsp_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .status    (status),
      .cmd       (cmd)
   );

   tcgr_dp #(
      .GLYPH_COUNT (GLYPH_COUNT)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .kind             (req_ch.kind),
      .char_code        (req_ch.char_code),
      .glyph_row        (req_ch.glyph_row),
      .font_byte        (req_ch.font_byte),
      .write_address    (rsp_ch.write_address),
      .pixel_0          (rsp_ch.pixel_0),
      .pixel_1          (rsp_ch.pixel_1),
      .pixel_2          (rsp_ch.pixel_2),
      .pixel_3          (rsp_ch.pixel_3),
      .pixel_4          (rsp_ch.pixel_4),
      .pixel_5          (rsp_ch.pixel_5),
      .pixel_6          (rsp_ch.pixel_6),
      .pixel_7          (rsp_ch.pixel_7),
      .last_row         (rsp_ch.last_row),
      .cmd              (cmd),
      .status           (status)
   );

endmodule

// ----- rtl/tcgr_ram.sv -----
module tcgr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     write_enable,
   input  logic                     read_enable,
   input  logic [$clog2(DEPTH)-1:0] address,
   input  logic [WIDTH-1:0]         write_data,
   output logic [WIDTH-1:0]         read_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] read_data_ff;

   // Single port, read data registered and held between reads
   always_ff @(posedge clock) begin
      if (write_enable) begin
         mem_ff[address] <= write_data;
      end
      if (read_enable) begin
         read_data_ff <= mem_ff[address];
      end
   end

   assign read_data = read_data_ff;

endmodule

// ----- rtl/tcgr_ctrl.sv -----
module tcgr_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic                   rsp_ready,
   output logic                   rsp_valid,
   input  tcgr_pkg::dp_status_type status,
   output tcgr_pkg::dp_cmd_type    cmd
);
   import tcgr_pkg::*;

   ctrl_state_type       state_ff, state_in;
   logic [ROW_CNT_W-1:0] issue_cnt_ff, issue_cnt_in;
   logic                 rd_pending_ff, rd_pending_in;
   logic                 out_valid_ff, out_valid_in;

   logic accept;
   logic rows_done;
   logic out_free;
   logic load_out;
   logic issue;

   // State and counters
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         issue_cnt_ff  <= '0;
         rd_pending_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         issue_cnt_ff  <= issue_cnt_in;
         rd_pending_ff <= rd_pending_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   // Next state and commands
   always_comb begin
      req_ready = (state_ff == ST_IDLE);
      accept    = req_valid && req_ready;
      rows_done = (issue_cnt_ff == ROW_CNT_W'(GLYPH_ROWS));
      out_free  = !out_valid_ff || rsp_ready;
      load_out  = (state_ff == ST_ROWS) && rd_pending_ff && out_free;
      issue     = (state_ff == ST_ROWS) && !rows_done && (!rd_pending_ff || load_out);

      state_in     = state_ff;
      issue_cnt_in = issue_cnt_ff;

      unique case (state_ff)
         ST_IDLE: begin
            issue_cnt_in = '0;
            if (accept && status.draw) begin
               state_in = ST_MULT;
            end
         end
         ST_MULT: begin
            state_in = ST_BASE;
         end
         ST_BASE: begin
            state_in = ST_ROWS;
         end
         ST_ROWS: begin
            if (issue) begin
               issue_cnt_in = issue_cnt_ff + ROW_CNT_W'(1);
            end
            // one read in flight at most, so the last load ends the glyph
            if (load_out && rows_done) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rd_pending_in = issue ? 1'b1 : (load_out ? 1'b0 : rd_pending_ff);
      out_valid_in  = load_out ? 1'b1 : (rsp_ready ? 1'b0 : out_valid_ff);

      cmd.accept    = accept;
      cmd.mult      = (state_ff == ST_MULT);
      cmd.base      = (state_ff == ST_BASE);
      cmd.issue     = issue;
      cmd.issue_row = issue_cnt_ff[ROW_W-1:0];
      cmd.load_out  = load_out;
      cmd.load_last = load_out && rows_done;
   end

   assign rsp_valid = out_valid_ff;

endmodule

// ----- rtl/tcgr_dp.sv -----
module tcgr_dp #(
   parameter int GLYPH_COUNT = tcgr_pkg::GLYPH_COUNT_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   // configuration
   input  logic                    csr_write_enable,
   input  tcgr_pkg::csr_index_type csr_index,
   input  logic [31:0]             csr_write_data,
   // input payload
   input  logic                    kind,
   input  logic [7:0]              char_code,
   input  logic [3:0]              glyph_row,
   input  logic [7:0]              font_byte,
   // result payload
   output logic [31:0]             write_address,
   output logic [31:0]             pixel_0,
   output logic [31:0]             pixel_1,
   output logic [31:0]             pixel_2,
   output logic [31:0]             pixel_3,
   output logic [31:0]             pixel_4,
   output logic [31:0]             pixel_5,
   output logic [31:0]             pixel_6,
   output logic [31:0]             pixel_7,
   output logic                    last_row,
   // control
   input  tcgr_pkg::dp_cmd_type    cmd,
   output tcgr_pkg::dp_status_type status
);
   import tcgr_pkg::*;

   localparam int FONT_DEPTH = GLYPH_COUNT * GLYPH_ROWS;
   localparam int FONT_AW    = $clog2(FONT_DEPTH);

   // Configuration registers
   logic [31:0] frame_base_ff;
   logic [15:0] line_pitch_ff;
   logic [5:0]  pixel_depth_ff;
   logic [7:0]  column_limit_ff;
   logic [4:0]  red_position_ff;
   logic [4:0]  green_position_ff;
   logic [4:0]  blue_position_ff;
   logic [11:0] channel_sizes_ff;

   // Cursor
   logic [8:0]  cursor_column_ff, cursor_column_in;
   logic [15:0] cursor_line_ff, cursor_line_in;

   // Per character working registers
   logic [7:0]  code_ff;
   logic        code_ok_ff;
   logic [31:0] line_prod_ff;
   logic [14:0] column_prod_ff;
   logic [31:0] colour_ff;
   logic [31:0] row_address_ff;

   // Output register
   logic [31:0] write_address_ff;
   logic [7:0]  bits_ff;
   logic [31:0] out_colour_ff;
   logic        last_row_ff;

   logic        is_print;
   logic        is_newline;
   logic        is_tab;
   logic        in_code_ok;
   logic        depth_ok;
   logic        font_write;
   logic [8:0]  column_step;
   logic [31:0] colour;
   logic [31:0] base_address;
   logic [11:0] write_index;
   logic [11:0] read_index;
   logic [FONT_AW-1:0] font_address;
   logic [7:0]  font_data;

   // Packs one gray channel at its bit position
   function automatic logic [31:0] place_channel(input logic [7:0] value,
                                                 input logic [4:0] position);
      logic [39:0] wide;
      wide = {32'd0, value} << position;
      return wide[31:0];
   endfunction

   // Gray cut to the channel size, sizes above 8 stay at 8
   function automatic logic [7:0] reduce_channel(input logic [3:0] size);
      logic [3:0] clipped;
      clipped = (size > CHAN_MAX) ? CHAN_MAX : size;
      return GREY >> (CHAN_MAX - clipped);
   endfunction

   // Decode of the offered input beat
   always_comb begin
      is_print   = (item_kind_type'(kind) == KIND_PRINT);
      is_newline = is_print && (char_code == CODE_LF);
      is_tab     = is_print && (char_code == CODE_TAB);
      depth_ok   = (pixel_depth_ff == DEPTH_16) || (pixel_depth_ff == DEPTH_32);
      in_code_ok = ({1'b0, char_code} < 9'(GLYPH_COUNT));
      font_write = cmd.accept && !is_print && in_code_ok;
      status.draw = is_print && (char_code != CODE_NUL) && !is_newline && !is_tab
                    && depth_ok;
   end

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_base_ff     <= FRAME_BASE_RST;
         line_pitch_ff     <= LINE_PITCH_RST;
         pixel_depth_ff    <= PIXEL_DEPTH_RST;
         column_limit_ff   <= COLUMN_LIMIT_RST;
         red_position_ff   <= RED_POSITION_RST;
         green_position_ff <= GREEN_POSITION_RST;
         blue_position_ff  <= BLUE_POSITION_RST;
         channel_sizes_ff  <= CHANNEL_SIZES_RST;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_FRAME_BASE:     frame_base_ff     <= csr_write_data;
            CSR_LINE_PITCH:     line_pitch_ff     <= csr_write_data[15:0];
            CSR_PIXEL_DEPTH:    pixel_depth_ff    <= csr_write_data[5:0];
            CSR_COLUMN_LIMIT:   column_limit_ff   <= csr_write_data[7:0];
            CSR_RED_POSITION:   red_position_ff   <= csr_write_data[4:0];
            CSR_GREEN_POSITION: green_position_ff <= csr_write_data[4:0];
            CSR_BLUE_POSITION:  blue_position_ff  <= csr_write_data[4:0];
            CSR_CHANNEL_SIZES:  channel_sizes_ff  <= csr_write_data[11:0];
            default: ;
         endcase
      end
   end

   // Cursor moves: newline and tab on accept, column advance at the base step of a drawn character
   always_comb begin
      cursor_column_in = cursor_column_ff;
      cursor_line_in   = cursor_line_ff;
      column_step      = cursor_column_ff + 9'd1;
      if (cmd.accept && is_newline) begin
         cursor_column_in = '0;
         cursor_line_in   = cursor_line_ff + 16'd1;
      end else if (cmd.accept && is_tab) begin
         cursor_column_in = {cursor_column_ff[8:3] + 6'd1, 3'd0};
      end else if (cmd.base) begin
         if (column_step > {1'b0, column_limit_ff}) begin
            cursor_column_in = '0;
            cursor_line_in   = cursor_line_ff + 16'd1;
         end else begin
            cursor_column_in = column_step;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_column_ff <= '0;
         cursor_line_ff   <= '0;
      end else begin
         cursor_column_ff <= cursor_column_in;
         cursor_line_ff   <= cursor_line_in;
      end
   end

   // Foreground color from the channel layout
   always_comb begin
      if (pixel_depth_ff == DEPTH_16) begin
         colour = place_channel(reduce_channel(channel_sizes_ff[3:0]), red_position_ff)
                | place_channel(reduce_channel(channel_sizes_ff[7:4]), green_position_ff)
                | place_channel(reduce_channel(channel_sizes_ff[11:8]), blue_position_ff);
         colour = {16'd0, colour[15:0]};
      end else begin
         colour = place_channel(GREY, red_position_ff)
                | place_channel(GREY, green_position_ff)
                | place_channel(GREY, blue_position_ff);
      end
   end

   assign base_address = frame_base_ff + {line_prod_ff[27:0], 4'd0}
                       + {17'd0, column_prod_ff};

   // Character setup and row address walk
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         code_ff    <= char_code;
         code_ok_ff <= in_code_ok;
      end
      if (cmd.mult) begin
         line_prod_ff   <= cursor_line_ff * line_pitch_ff;
         column_prod_ff <= cursor_column_ff * pixel_depth_ff;
         colour_ff      <= colour;
      end
      if (cmd.base) begin
         row_address_ff <= base_address;
      end else if (cmd.load_out) begin
         row_address_ff <= row_address_ff + {16'd0, line_pitch_ff};
      end
   end

   // Font store: writes on accept, reads while rows are issued
   assign write_index  = {char_code, glyph_row};
   assign read_index   = {code_ff, cmd.issue_row};
   assign font_address = font_write ? write_index[FONT_AW-1:0] : read_index[FONT_AW-1:0];

   tcgr_ram #(
      .WIDTH (8),
      .DEPTH (FONT_DEPTH)
   ) u_font_ram (
      .clock        (clock),
      .write_enable (font_write),
      .read_enable  (cmd.issue && code_ok_ff),
      .address      (font_address),
      .write_data   (font_byte),
      .read_data    (font_data)
   );

   // Output register
   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         write_address_ff <= row_address_ff;
         bits_ff          <= code_ok_ff ? font_data : 8'd0;
         out_colour_ff    <= colour_ff;
         last_row_ff      <= cmd.load_last;
      end
   end

   assign write_address = write_address_ff;
   assign pixel_0       = bits_ff[7] ? out_colour_ff : 32'd0;
   assign pixel_1       = bits_ff[6] ? out_colour_ff : 32'd0;
   assign pixel_2       = bits_ff[5] ? out_colour_ff : 32'd0;
   assign pixel_3       = bits_ff[4] ? out_colour_ff : 32'd0;
   assign pixel_4       = bits_ff[3] ? out_colour_ff : 32'd0;
   assign pixel_5       = bits_ff[2] ? out_colour_ff : 32'd0;
   assign pixel_6       = bits_ff[1] ? out_colour_ff : 32'd0;
   assign pixel_7       = bits_ff[0] ? out_colour_ff : 32'd0;
   assign last_row      = last_row_ff;

endmodule

// ----- verif/tcgr_render_check.sv -----
`timescale 1ns / 100ps
module tcgr_render_check #(
   parameter int GLYPH_COUNT = tcgr_pkg::GLYPH_COUNT_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   tcgr_req_if                     req_mon,
   tcgr_rsp_if                     rsp_mon,
   input  logic                    csr_write_enable,
   input  tcgr_pkg::csr_index_type csr_index,
   input  logic [31:0]             csr_write_data,
   output int                      rows_pending,
   output int                      rows_checked,
   output int                      mismatch_count
);
   import tcgr_pkg::*;

   // One framebuffer write: address, eight pixels (index 0 leftmost), end-of-glyph flag
   typedef struct packed {
      logic [31:0]      address;
      logic [7:0][31:0] pixels;
      logic             last;
   } row_write_type;

   // Shadow copy of the register file
   logic [31:0] frame_base;
   logic [15:0] line_pitch;
   logic [5:0]  pixel_depth;
   logic [7:0]  column_limit;
   logic [4:0]  red_pos;
   logic [4:0]  green_pos;
   logic [4:0]  blue_pos;
   logic [11:0] channel_sizes;

   // Cursor and font image
   logic [8:0]  cursor_col;
   logic [15:0] cursor_line;
   logic [7:0]  font_rows [GLYPH_COUNT * GLYPH_ROWS];

   row_write_type rows_due[$];
   int            checked_total = 0;
   int            mismatches    = 0;

   // One gray channel placed at its bit position; 16 bpp cuts it down to its size
   function automatic logic [63:0] grey_field(input logic [3:0] size, input logic [4:0] pos,
                                              input logic reduce);
      logic [63:0] v;
      int          bits;
      bits = (size > CHAN_MAX) ? 8 : int'(size);
      v = 64'(GREY);
      if (reduce)
         v = v >> (8 - bits);
      return v << pos;
   endfunction

   function automatic logic [31:0] grey_pixel();
      logic [63:0] c;
      logic        narrow;
      narrow = (pixel_depth == DEPTH_16);
      c = grey_field(channel_sizes[3:0], red_pos, narrow)
        | grey_field(channel_sizes[7:4], green_pos, narrow)
        | grey_field(channel_sizes[11:8], blue_pos, narrow);
      return narrow ? {16'd0, c[15:0]} : c[31:0];
   endfunction

   // Update the font or cursor for one request beat, queue any row writes it draws
   task automatic predict_beat(input logic kind, input logic [7:0] code, input logic [3:0] row,
                               input logic [7:0] fbyte);
      logic [31:0]   origin;
      logic [31:0]   colour;
      logic [31:0]   pitch32;
      logic [7:0]    bits;
      row_write_type beat;
      pitch32 = 32'(line_pitch);
      if (kind == KIND_FONT) begin
         if (int'(code) < GLYPH_COUNT)
            font_rows[int'(code) * GLYPH_ROWS + int'(row)] = fbyte;
      end else if (code == CODE_NUL) begin
         // nothing moves
      end else if (code == CODE_LF) begin
         cursor_line = cursor_line + 16'd1;
         cursor_col  = '0;
      end else if (code == CODE_TAB) begin
         // next multiple of 8, no limit check, 9-bit wrap
         cursor_col = cursor_col + (9'd8 - {6'd0, cursor_col[2:0]});
      end else if (pixel_depth == DEPTH_16 || pixel_depth == DEPTH_32) begin
         colour = grey_pixel();
         origin = frame_base + 32'(cursor_line) * pitch32 * 32'd16
                + 32'(cursor_col) * 32'(pixel_depth);
         for (int r = 0; r < GLYPH_ROWS; r++) begin
            bits = (int'(code) < GLYPH_COUNT) ? font_rows[int'(code) * GLYPH_ROWS + r] : 8'h00;
            beat.address = origin + 32'(r) * pitch32;
            for (int p = 0; p < 8; p++)
               beat.pixels[p] = bits[7 - p] ? colour : 32'd0;
            beat.last = (r == GLYPH_ROWS - 1);
            rows_due.push_back(beat);
         end
         cursor_col = cursor_col + 9'd1;
         if (cursor_col > {1'b0, column_limit}) begin
            cursor_col  = '0;
            cursor_line = cursor_line + 16'd1;
         end
      end
   endtask

   task automatic compare_field(input string field, input logic [31:0] want,
                                input logic [31:0] got);
      if (got !== want) begin
         mismatches++;
         $error("%s: expected 0x%08h, got 0x%08h", field, want, got);
      end
   endtask

   // Compare one row beat against the oldest row still due
   task automatic check_row();
      row_write_type    want;
      logic [7:0][31:0] seen;
      seen = {rsp_mon.pixel_7, rsp_mon.pixel_6, rsp_mon.pixel_5, rsp_mon.pixel_4,
              rsp_mon.pixel_3, rsp_mon.pixel_2, rsp_mon.pixel_1, rsp_mon.pixel_0};
      if (rows_due.size() == 0) begin
         mismatches++;
         $error("row write to 0x%08h with none due", rsp_mon.write_address);
         return;
      end
      want = rows_due.pop_front();
      checked_total++;
      compare_field("write_address", want.address, rsp_mon.write_address);
      for (int i = 0; i < 8; i++)
         compare_field($sformatf("pixel_%0d", i), want.pixels[i], seen[i]);
      compare_field("last_row", 32'(want.last), 32'(rsp_mon.last_row));
   endtask

   // Register writes, request beats and row beats in edge order
   always @(posedge clock) begin
      if (reset) begin
         frame_base    = FRAME_BASE_RST;
         line_pitch    = LINE_PITCH_RST;
         pixel_depth   = PIXEL_DEPTH_RST;
         column_limit  = COLUMN_LIMIT_RST;
         red_pos       = RED_POSITION_RST;
         green_pos     = GREEN_POSITION_RST;
         blue_pos      = BLUE_POSITION_RST;
         channel_sizes = CHANNEL_SIZES_RST;
         cursor_col    = '0;
         cursor_line   = '0;
         rows_due.delete();
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               CSR_FRAME_BASE:     frame_base    = csr_write_data;
               CSR_LINE_PITCH:     line_pitch    = csr_write_data[15:0];
               CSR_PIXEL_DEPTH:    pixel_depth   = csr_write_data[5:0];
               CSR_COLUMN_LIMIT:   column_limit  = csr_write_data[7:0];
               CSR_RED_POSITION:   red_pos       = csr_write_data[4:0];
               CSR_GREEN_POSITION: green_pos     = csr_write_data[4:0];
               CSR_BLUE_POSITION:  blue_pos      = csr_write_data[4:0];
               CSR_CHANNEL_SIZES:  channel_sizes = csr_write_data[11:0];
               default: ;
            endcase
         end
         if (req_mon.valid === 1'b1 && req_mon.ready === 1'b1)
            predict_beat(req_mon.kind, req_mon.char_code, req_mon.glyph_row, req_mon.font_byte);
         if (rsp_mon.valid === 1'b1 && rsp_mon.ready === 1'b1)
            check_row();
      end
      rows_pending   <= rows_due.size();
      rows_checked   <= checked_total;
      mismatch_count <= mismatches;
   end

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 100ps
module tb;
   import tcgr_pkg::*;

   localparam int CYCLE_LIMIT   = 1_000_000;
   localparam int SETTLE_CYCLES = 25;
   localparam int LONG_HOLD     = 300;
   // full, empty, single-pixel and checker rows for the corner glyph
   localparam logic [5:0][7:0] EDGE_ROWS = {8'h55, 8'hAA, 8'h01, 8'h80, 8'h00, 8'hFF};

   logic          clock;
   logic          reset;
   logic          csr_write_enable;
   csr_index_type csr_index;
   logic [31:0]   csr_write_data;
   int            rows_pending;
   int            rows_checked;
   int            mismatch_count;

   tcgr_req_if req_ch();
   tcgr_rsp_if rsp_ch();

   // Which glyph rows have been loaded; only fully loaded glyphs get printed
   logic [15:0] rows_loaded [256] = '{default: 16'h0000};
   logic [7:0]  drawable_codes[$];

   int beats_sent       = 0;
   int settings_applied = 0;
   int cycle_count      = 0;
   int send_calm        = 0;
   int holds_asked      = 0;
   bit steady_send      = 1'b0;

   text_console_glyph_renderer_top dut (
      .clock            (clock),
      .reset            (reset),
      .req_ch           (req_ch),
      .rsp_ch           (rsp_ch),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   tcgr_render_check render_check (
      .clock            (clock),
      .reset            (reset),
      .req_mon          (req_ch),
      .rsp_mon          (rsp_ch),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .rows_pending     (rows_pending),
      .rows_checked     (rows_checked),
      .mismatch_count   (mismatch_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Run guard
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // Offer one request beat after a random gap and wait until it is taken
   task automatic send_beat(input logic kind, input logic [7:0] code, input logic [3:0] row,
                            input logic [7:0] fbyte);
      int gap;
      if (steady_send || send_calm > 0) begin
         gap = 0;
         if (send_calm > 0)
            send_calm--;
      end else begin
         gap = $urandom_range(0, 5);
         if ($urandom_range(0, 24) == 0)
            send_calm = $urandom_range(20, 40);
      end
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.kind      <= kind;
      req_ch.char_code <= code;
      req_ch.glyph_row <= row;
      req_ch.font_byte <= fbyte;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      beats_sent++;
      if (kind == KIND_FONT && rows_loaded[code] != 16'hFFFF) begin
         rows_loaded[code][row] = 1'b1;
         if (rows_loaded[code] == 16'hFFFF)
            drawable_codes.push_back(code);
      end
   endtask

   // Print beat; row and byte are don't-care but toggled anyway
   task automatic print_code(input logic [7:0] code);
      send_beat(KIND_PRINT, code, 4'($urandom), 8'($urandom));
   endtask

   task automatic print_drawable();
      print_code(drawable_codes[$urandom_range(0, drawable_codes.size() - 1)]);
   endtask

   task automatic load_glyph(input logic [7:0] code);
      for (int r = 0; r < GLYPH_ROWS; r++)
         send_beat(KIND_FONT, code, 4'(r), 8'($urandom));
   endtask

   // Drop valid, let every due row drain, then let the block settle
   task automatic wait_idle();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (rows_pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Unused upper data bits carry noise
   task automatic write_reg(input csr_index_type idx, input logic [31:0] value);
      logic [31:0] keep;
      case (idx)
         CSR_FRAME_BASE:    keep = 32'hFFFF_FFFF;
         CSR_LINE_PITCH:    keep = 32'h0000_FFFF;
         CSR_PIXEL_DEPTH:   keep = 32'h0000_003F;
         CSR_COLUMN_LIMIT:  keep = 32'h0000_00FF;
         CSR_CHANNEL_SIZES: keep = 32'h0000_0FFF;
         default:           keep = 32'h0000_001F;
      endcase
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= (value & keep) | ($urandom & ~keep);
      @(posedge clock);
   endtask

   task automatic set_config(input logic [31:0] base, input logic [15:0] pitch,
                             input logic [5:0] depth, input logic [7:0] limit,
                             input logic [4:0] red, input logic [4:0] green,
                             input logic [4:0] blue, input logic [11:0] sizes);
      wait_idle();
      write_reg(CSR_FRAME_BASE, base);
      write_reg(CSR_LINE_PITCH, 32'(pitch));
      write_reg(CSR_PIXEL_DEPTH, 32'(depth));
      write_reg(CSR_COLUMN_LIMIT, 32'(limit));
      write_reg(CSR_RED_POSITION, 32'(red));
      write_reg(CSR_GREEN_POSITION, 32'(green));
      write_reg(CSR_BLUE_POSITION, 32'(blue));
      write_reg(CSR_CHANNEL_SIZES, 32'(sizes));
      csr_write_enable <= 1'b0;
      settings_applied++;
   endtask

   // Mostly prints of loaded glyphs, with glyph loads, cursor moves and stray writes
   task automatic run_random(input int count);
      int         done;
      int         pick;
      logic [7:0] code;
      done = 0;
      while (done < count) begin
         pick = $urandom_range(0, 99);
         code = 8'($urandom);
         if (pick < 12) begin
            load_glyph(code);
            done += GLYPH_ROWS;
         end else begin
            if (pick < 22)
               send_beat(KIND_FONT, code, 4'($urandom), 8'($urandom));
            else if (pick < 32)
               print_code(CODE_LF);
            else if (pick < 42)
               print_code(CODE_TAB);
            else if (pick < 47)
               print_code(CODE_NUL);
            else
               print_drawable();
            done++;
         end
      end
   endtask

   // Row sink: random stall per beat, calm stretches, long holds on request
   initial begin : row_sink
      int stall;
      int calm;
      int holds_done;
      calm       = 0;
      holds_done = 0;
      rsp_ch.ready <= 1'b0;
      do @(posedge clock); while (reset !== 1'b0);
      forever begin
         if (holds_done < holds_asked) begin
            stall = LONG_HOLD;
            holds_done++;
         end else if (calm > 0) begin
            stall = 0;
            calm--;
         end else begin
            stall = $urandom_range(0, 5);
            if ($urandom_range(0, 24) == 0)
               calm = $urandom_range(20, 40);
         end
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (rsp_ch.valid !== 1'b1);
      end
   end

   initial begin : stimulus
      logic [5:0] depth;
      reset            <= 1'b1;
      csr_write_enable <= 1'b0;
      csr_index        <= CSR_FRAME_BASE;
      csr_write_data   <= '0;
      req_ch.valid     <= 1'b0;
      req_ch.kind      <= KIND_PRINT;
      req_ch.char_code <= '0;
      req_ch.glyph_row <= '0;
      req_ch.font_byte <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Reset settings: corner glyph in the top code slot, then every print operation
      for (int r = 0; r < GLYPH_ROWS; r++)
         send_beat(KIND_FONT, 8'hFF, 4'(r), (r < 6) ? EDGE_ROWS[r] : 8'($urandom));
      print_code(8'hFF);
      print_code(CODE_TAB);
      print_code(8'hFF);
      print_code(CODE_LF);
      print_code(CODE_NUL);
      print_code(8'hFF);

      // 16 bpp 5-6-5, base near the top of memory, widest pitch, wrap after every char
      set_config(32'hFFFF_F000, 16'hFFFF, DEPTH_16, 8'd0, 5'd11, 5'd5, 5'd0, 12'h565);
      run_random(16);

      // 32 bpp with fields shifted off the top, zero pitch, widest column limit
      set_config(32'hFFFF_FFFF, 16'd0, DEPTH_32, 8'd255, 5'd31, 5'd24, 5'd0, 12'hFFF);
      steady_send = 1'b1;
      repeat (64) print_code(CODE_TAB);
      steady_send = 1'b0;
      print_drawable();
      // Sink holds off while a burst of characters backs up into the input
      holds_asked++;
      repeat (8) print_drawable();
      run_random(8);

      // 16 bpp with zero and oversized channel sizes, fields past bit 15
      set_config($urandom, 16'd640, DEPTH_16, 8'd3, 5'd31, 5'd31, 5'd15, 12'h0F0);
      run_random(10);

      // Depths that draw nothing
      set_config($urandom, 16'($urandom), 6'd63, 8'($urandom), 5'($urandom), 5'($urandom),
                 5'($urandom), 12'($urandom));
      run_random(6);
      set_config($urandom, 16'($urandom), 6'd0, 8'($urandom), 5'($urandom), 5'($urandom),
                 5'($urandom), 12'($urandom));
      run_random(6);

      // A short newline run, then characters on the lines below
      set_config(32'h0000_1000, 16'd1, DEPTH_32, 8'd128, 5'd16, 5'd8, 5'd0, 12'd1416);
      steady_send = 1'b1;
      repeat (4) print_code(CODE_LF);
      steady_send = 1'b0;
      print_drawable();
      print_code(CODE_LF);
      print_drawable();

      // Fully random settings
      repeat (3) begin
         case ($urandom_range(0, 2))
            0:       depth = DEPTH_16;
            1:       depth = DEPTH_32;
            default: depth = 6'($urandom);
         endcase
         set_config($urandom, 16'($urandom), depth, 8'($urandom), 5'($urandom), 5'($urandom),
                    5'($urandom), 12'($urandom));
         run_random(8);
      end

      wait_idle();
      $display("Run covered %0d request beats and %0d glyph row writes over %0d settings,",
               beats_sent, rows_checked, settings_applied + 1);
      $display("with font loads, tabs, newlines, cursor wraps and non-drawing depths.");
      if (mismatch_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
